FILE: sv/assert_macros.svh
// Assertion macros for the RTL files that carry checks (here dfs_topological_sort).
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent on one edge, consequent on the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/dts_pkg.sv
// Shared types and codes of the DFS topological sort block.
// No dependencies.
`timescale 1ns / 1ps

package dts_pkg;

    localparam int VERTEX_W = 6;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 7;

    localparam logic [STATUS_W-1:0] ST_ORDER = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CYCLE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

    typedef struct packed {
        logic ld_start;
        logic ld_finish;
        logic run_init;
        logic root_next;
        logic root_open;
        logic push_head;
        logic step_finish;
        logic pop_load;
        logic edge_take;
        logic edge_err;
        logic edge_push;
        logic cycle_set;
        logic out_single;
        logic idx_init;
        logic out_item;
        logic idx_dec;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic load_ok;
        logic root_done;
        logic root_visited;
        logic e_nil;
        logic depth_one;
        logic depth_full;
        logic w_bad;
        logic w_visited;
        logic w_onstack;
        logic single;
        logic out_valid;
        logic out_last;
    } stat_t;

endpackage

FILE: sv/dts_ctrl.sv
// Sequencer of the DFS topological sort: loads, graph walk, result emission.
// Depends on dts_pkg; drives dts_datapath through cmd_t and reads stat_t.
`timescale 1ns / 1ps

module dts_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_func,
    output logic          in_ready,
    input  logic          out_ready,
    input  dts_pkg::stat_t stat,
    output dts_pkg::cmd_t  cmd
);
    import dts_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LD_WR = 4'd1;
    localparam logic [3:0] S_ROOT  = 4'd2;
    localparam logic [3:0] S_PUSHH = 4'd3;
    localparam logic [3:0] S_STEP  = 4'd4;
    localparam logic [3:0] S_POP   = 4'd5;
    localparam logic [3:0] S_EDGE  = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;
    localparam logic [3:0] S_RD    = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_WAIT  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_func == FUNC_LOAD)
                    begin
                        cmd.ld_start = 1'b1;
                        if (stat.load_ok)
                            state_next = S_LD_WR;
                    end
                    else
                    begin
                        cmd.run_init = 1'b1;
                        state_next   = S_ROOT;
                    end
                end
            end
            S_LD_WR:
            begin
                cmd.ld_finish = 1'b1;
                state_next    = S_IDLE;
            end
            S_ROOT:
            begin
                priority if (stat.root_done)
                    state_next = S_DONE;
                else if (stat.root_visited)
                    cmd.root_next = 1'b1;
                else
                begin
                    cmd.root_open = 1'b1;
                    state_next    = S_PUSHH;
                end
            end
            S_PUSHH:
            begin
                cmd.push_head = 1'b1;
                state_next    = S_STEP;
            end
            S_STEP:
            begin
                if (stat.e_nil)
                begin
                    cmd.step_finish = 1'b1;
                    if (stat.depth_one)
                    begin
                        cmd.root_next = 1'b1;
                        state_next    = S_ROOT;
                    end
                    else
                        state_next = S_POP;
                end
                else
                    state_next = S_EDGE;
            end
            S_POP:
            begin
                cmd.pop_load = 1'b1;
                state_next   = S_STEP;
            end
            S_EDGE:
            begin
                cmd.edge_take = 1'b1;
                state_next    = S_STEP;
                priority if (stat.w_bad)
                    cmd.edge_err = 1'b1;
                else if (!stat.w_visited)
                begin
                    if (!stat.depth_full)
                    begin
                        cmd.edge_push = 1'b1;
                        state_next    = S_PUSHH;
                    end
                end
                else if (stat.w_onstack)
                begin
                    cmd.cycle_set = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.single)
                begin
                    cmd.out_single = 1'b1;
                    state_next     = S_WAIT;
                end
                else
                begin
                    cmd.idx_init = 1'b1;
                    state_next   = S_RD;
                end
            end
            S_RD:
                state_next = S_OUT;
            S_OUT:
            begin
                cmd.out_item = 1'b1;
                state_next   = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.out_valid && out_ready)
                begin
                    if (stat.out_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_dec = 1'b1;
                        state_next  = S_RD;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: sv/dts_datapath.sv
// Datapath of the DFS topological sort: edge store, adjacency heads/tails,
// marks, walk stack, finish order and output register. Depends on dts_pkg.
`timescale 1ns / 1ps

module dts_datapath #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dts_pkg::cmd_t                 cmd,
    output dts_pkg::stat_t                stat,
    input  logic [dts_pkg::VERTEX_W-1:0]  in_from,
    input  logic [dts_pkg::VERTEX_W-1:0]  in_to,
    input  logic                          cfg_we,
    input  logic [dts_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [dts_pkg::VERTEX_W-1:0]  out_vertex,
    output logic [dts_pkg::STATUS_W-1:0]  out_status,
    output logic                          out_last
);
    import dts_pkg::*;

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam logic [EW-1:0] NIL = EW'(MAX_EDGES);
    localparam logic [VW:0]   VMAX = (VW+1)'(MAX_VERTICES);

    logic [CFG_W-1:0] vcount_reg;
    logic [CFG_W-1:0] n_eff;

    logic [EW-1:0]           cnt_reg;
    logic                    err_reg;
    logic                    cyc_reg;
    logic [MAX_VERTICES-1:0] head_valid_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [MAX_VERTICES-1:0] onstack_reg;
    logic [VW:0]             root_reg;
    logic [VW:0]             depth_reg;
    logic [VW-1:0]           top_v_reg;
    logic [EW-1:0]           top_e_reg;
    logic [VW:0]             nf_reg;
    logic [VW-1:0]           idx_reg;
    logic [VW-1:0]           ld_from_reg;
    logic [EIW-1:0]          ld_slot_reg;

    logic [VW-1:0]   target_mem [MAX_EDGES];
    logic [EIW-1:0]  link_mem   [MAX_EDGES];
    logic [EIW-1:0]  head_mem   [MAX_VERTICES];
    logic [EIW-1:0]  tail_mem   [MAX_VERTICES];
    logic [VW+EW-1:0] stack_mem [MAX_VERTICES];
    logic [VW-1:0]   fin_mem    [MAX_VERTICES];

    logic [VW-1:0]    target_q;
    logic [EIW-1:0]   link_q;
    logic [EIW-1:0]   head_q;
    logic [EIW-1:0]   tail_q;
    logic [VW+EW-1:0] stack_q;
    logic [VW-1:0]    fin_q;

    logic [VW-1:0]  from_v;
    logic [VW-1:0]  to_v;
    logic [VW-1:0]  w;
    logic [EW-1:0]  next_e;
    logic [VW:0]    depth_m1;
    logic [VW:0]    depth_m2;
    logic [VW:0]    nf_m1;
    logic [VW-1:0]  tail_raddr;
    logic [VW-1:0]  head_raddr;
    logic           load_ok;

    always_comb
    begin
        priority if (vcount_reg == '0)
            n_eff = CFG_W'(1);
        else if (vcount_reg > CFG_W'(MAX_VERTICES))
            n_eff = CFG_W'(MAX_VERTICES);
        else
            n_eff = vcount_reg;
    end

    assign from_v   = in_from[VW-1:0];
    assign to_v     = in_to[VW-1:0];
    assign load_ok  = (CFG_W'(in_from) < n_eff) && (CFG_W'(in_to) < n_eff)
                      && (cnt_reg < NIL);
    assign w        = target_q;
    assign next_e   = (top_e_reg[EIW-1:0] == tail_q) ? NIL : EW'(link_q);
    assign depth_m1 = depth_reg - (VW+1)'(1);
    assign depth_m2 = depth_reg - (VW+1)'(2);
    assign nf_m1    = nf_reg - (VW+1)'(1);
    assign tail_raddr = cmd.ld_start ? from_v : top_v_reg;
    assign head_raddr = cmd.root_open ? root_reg[VW-1:0] : w;

    assign stat.load_ok      = load_ok;
    assign stat.root_done    = CFG_W'(root_reg) >= n_eff;
    assign stat.root_visited = visited_reg[root_reg[VW-1:0]];
    assign stat.e_nil        = (top_e_reg == NIL);
    assign stat.depth_one    = (depth_reg == (VW+1)'(1));
    assign stat.depth_full   = (depth_reg >= VMAX);
    assign stat.w_bad        = CFG_W'(w) >= n_eff;
    assign stat.w_visited    = visited_reg[w];
    assign stat.w_onstack    = onstack_reg[w];
    assign stat.single       = err_reg || cyc_reg || (nf_reg == '0);
    assign stat.out_valid    = out_valid;
    assign stat.out_last     = out_last;

    // memories: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.ld_start && load_ok)
            target_mem[cnt_reg[EIW-1:0]] <= to_v;
        if (cmd.ld_finish && head_valid_reg[ld_from_reg])
            link_mem[tail_q] <= ld_slot_reg;
        if (cmd.ld_finish && !head_valid_reg[ld_from_reg])
            head_mem[ld_from_reg] <= ld_slot_reg;
        if (cmd.ld_finish)
            tail_mem[ld_from_reg] <= ld_slot_reg;
        if (cmd.edge_push)
            stack_mem[depth_m1[VW-1:0]] <= {top_v_reg, next_e};
        if (cmd.step_finish && (nf_reg < VMAX))
            fin_mem[nf_reg[VW-1:0]] <= top_v_reg;

        target_q <= target_mem[top_e_reg[EIW-1:0]];
        link_q   <= link_mem[top_e_reg[EIW-1:0]];
        head_q   <= head_mem[head_raddr];
        tail_q   <= tail_mem[tail_raddr];
        stack_q  <= stack_mem[depth_m2[VW-1:0]];
        fin_q    <= fin_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_start)
        begin
            ld_from_reg <= from_v;
            ld_slot_reg <= cnt_reg[EIW-1:0];
        end
        if (cmd.root_open)
            top_v_reg <= root_reg[VW-1:0];
        else if (cmd.edge_push)
            top_v_reg <= w;
        else if (cmd.pop_load)
            top_v_reg <= stack_q[VW+EW-1:EW];
        if (cmd.push_head)
            top_e_reg <= head_valid_reg[top_v_reg] ? EW'(head_q) : NIL;
        else if (cmd.pop_load)
            top_e_reg <= stack_q[EW-1:0];
        else if (cmd.edge_take)
            top_e_reg <= next_e;
        if (cmd.idx_init)
            idx_reg <= nf_m1[VW-1:0];
        else if (cmd.idx_dec)
            idx_reg <= idx_reg - VW'(1);
        if (cmd.out_single)
        begin
            out_vertex <= '0;
            out_status <= err_reg ? ST_ERROR : ST_CYCLE;
            out_last   <= 1'b1;
        end
        else if (cmd.out_item)
        begin
            out_vertex <= VERTEX_W'(fin_q);
            out_status <= ST_ORDER;
            out_last   <= (idx_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg     <= CFG_W'(1);
            cnt_reg        <= '0;
            err_reg        <= 1'b0;
            cyc_reg        <= 1'b0;
            head_valid_reg <= '0;
            visited_reg    <= '0;
            onstack_reg    <= '0;
            root_reg       <= '0;
            depth_reg      <= '0;
            nf_reg         <= '0;
            out_valid      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                vcount_reg <= cfg_data;
            if (cmd.ld_start && !load_ok)
                err_reg <= 1'b1;
            if (cmd.edge_err)
                err_reg <= 1'b1;
            if (cmd.ld_start && load_ok)
                cnt_reg <= cnt_reg + EW'(1);
            if (cmd.ld_finish)
                head_valid_reg[ld_from_reg] <= 1'b1;
            if (cmd.cycle_set)
                cyc_reg <= 1'b1;
            if (cmd.run_init)
            begin
                root_reg <= '0;
                nf_reg   <= '0;
            end
            else if (cmd.root_next)
                root_reg <= root_reg + (VW+1)'(1);
            if (cmd.root_open)
            begin
                visited_reg[root_reg[VW-1:0]] <= 1'b1;
                onstack_reg[root_reg[VW-1:0]] <= 1'b1;
                depth_reg <= (VW+1)'(1);
            end
            if (cmd.edge_push)
            begin
                visited_reg[w] <= 1'b1;
                onstack_reg[w] <= 1'b1;
                depth_reg      <= depth_reg + (VW+1)'(1);
            end
            if (cmd.step_finish)
            begin
                onstack_reg[top_v_reg] <= 1'b0;
                depth_reg              <= depth_m1;
                if (nf_reg < VMAX)
                    nf_reg <= nf_reg + (VW+1)'(1);
            end
            if (cmd.out_single || cmd.out_item)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
            if (cmd.clear)
            begin
                cnt_reg        <= '0;
                err_reg        <= 1'b0;
                cyc_reg        <= 1'b0;
                head_valid_reg <= '0;
                visited_reg    <= '0;
                onstack_reg    <= '0;
            end
        end
    end

endmodule

FILE: sv/dfs_topological_sort.sv
// Top level of the DFS topological sort: stream ports, config port, checks.
// Depends on dts_pkg, dts_ctrl, dts_datapath and assert_macros.svh.
//
//  channel  | signals                          | moves
//  ---------+----------------------------------+------------------------------
//  s_axis   | tvalid tready tdata tuser        | edge load or run request
//  m_axis   | tvalid tready tdata tuser tlast  | order vertex or run status
//  cfg      | cfg_valid cfg_ready cfg_data     | vertex_count write
//
//  Edge load: tail read, then link/head/tail write.
//  Run: root, edge and vertex finish steps, one step per memory read
//  of the edge store, then read, output and wait per result plus stalls.
//  Marks, list heads and edge count clear when the last result is taken.
//  m_axis holds its result until taken; no request is taken during a run.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dfs_topological_sort #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [5:0] edge_from, [11:6] edge_to
    input  logic [0:0]  s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [5:0] vertex
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data        // vertex_count
);
    import dts_pkg::*;

    cmd_t                cmd;
    stat_t               stat;
    logic [VERTEX_W-1:0] out_vertex;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = {(8 - VERTEX_W)'(0), out_vertex};

    dts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_func   (s_axis_tuser[0]),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dts_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_from    (s_axis_tdata[5:0]),
        .in_to      (s_axis_tdata[11:6]),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_vertex (out_vertex),
        .out_status (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

    `ASSERT_CLK(a_no_req_while_result, m_axis_tvalid |-> !s_axis_tready, "request taken with result pending")
    `ASSERT_CLK(a_status_is_last, (m_axis_tvalid && m_axis_tuser != ST_ORDER) |-> m_axis_tlast, "status result not last")
    `ASSERT_NEXT(a_idle_after_last, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready && !m_axis_tvalid, "no return to idle after run")

endmodule
